// ===== hw/rtl/sh13_pkg.sv =====
// Shared types, constants and helper functions for the SipHash-1-3 stream block.
package sh13_pkg;

	localparam int WordW  = 64;
	localparam int BytesW = 4;
	localparam int CountW = 3;
	localparam int LenW   = 8;
	localparam int RegIdxW = 2;

	localparam logic [WordW-1:0] SipC0 = 64'h736f6d6570736575;
	localparam logic [WordW-1:0] SipC1 = 64'h646f72616e646f6d;
	localparam logic [WordW-1:0] SipC2 = 64'h6c7967656e657261;
	localparam logic [WordW-1:0] SipC3 = 64'h7465646279746573;
	localparam logic [WordW-1:0] FinLo = 64'h00000000000000ee;
	localparam logic [WordW-1:0] FinHi = 64'h00000000000000dd;

	// Configuration register indexes
	localparam logic [RegIdxW-1:0] RegKeyLow  = 2'd0;
	localparam logic [RegIdxW-1:0] RegKeyHigh = 2'd1;

	typedef struct packed {
		logic [WordW-1:0] v0;
		logic [WordW-1:0] v1;
		logic [WordW-1:0] v2;
		logic [WordW-1:0] v3;
	} sip_state_t;

	typedef struct packed {
		logic              full;
		logic [WordW-1:0]  word;
		logic [WordW-1:0]  part;
		logic [CountW-1:0] count;
		logic [LenW-1:0]   len;
	} pack_res_t;

	function automatic sip_state_t sip_init(input logic [WordW-1:0] k0,
	                                        input logic [WordW-1:0] k1);
		sip_state_t s;
		s.v0 = k0 ^ SipC0;
		s.v1 = k1 ^ SipC1 ^ FinLo;
		s.v2 = k0 ^ SipC2;
		s.v3 = k1 ^ SipC3;
		return s;
	endfunction

	function automatic logic [WordW-1:0] final_block(input logic [LenW-1:0] len,
	                                                 input logic [WordW-1:0] part);
		return {len, part[WordW-LenW-1:0]};
	endfunction

endpackage

// ===== hw/rtl/sh13_if.sv =====
// Valid/ready channel interfaces: message chunks, hash words, key writes.
interface sh13_chunk_if import sh13_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WordW-1:0]  chunk_data;
	logic [BytesW-1:0] chunk_bytes;
	logic              end_of_message;

	modport source (output valid, chunk_data, chunk_bytes, end_of_message, input ready);
	modport sink   (input valid, chunk_data, chunk_bytes, end_of_message, output ready);
endinterface

interface sh13_hash_if import sh13_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WordW-1:0] hash_word;
	logic             upper_half;
	logic             final_word;

	modport source (output valid, hash_word, upper_half, final_word, input ready);
	modport sink   (input valid, hash_word, upper_half, final_word, output ready);
endinterface

interface sh13_cfg_if import sh13_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [RegIdxW-1:0] reg_index;
	logic [WordW-1:0]   wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hw/rtl/siphash_1_3_128_stream.sv =====
// Top level of the streaming keyed SipHash-1-3 block with 128-bit result.
// Keyed SipHash-1-3 over a byte stream, 128-bit result. Load key_low
// (register 0) and key_high (register 1) through cfg; any key write restarts
// the message. Send chunks of 0 to 8 bytes, first byte in bits 7:0; a byte
// count above 8 counts as 8. All SipRounds run on one half-round unit under
// a small sequencer, and chunk.ready stays low while it works. A chunk that
// does not complete a 64-bit word is only merged into the partial word; one
// that completes a word also runs one compression round. The chunk marked
// end_of_message adds the final block round and the two three-round
// finalizations; the high half follows the low half, and either half is
// held back while hash is stalled. Two hash transfers follow each message,
// low half first (upper_half = final_word = 0), then the high half (both 1);
// the state then reloads from the keys. A next chunk is taken while the high
// half still waits in the output register.
module siphash_1_3_128_stream import sh13_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sh13_chunk_if.sink  chunk,
	sh13_hash_if.source hash,
	sh13_cfg_if.sink    cfg
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RND  = 1'b1;

	// What to do when the current run of rounds ends
	localparam logic [1:0] STEP_MSG = 2'd0;
	localparam logic [1:0] STEP_FIN = 2'd1;
	localparam logic [1:0] STEP_LO  = 2'd2;
	localparam logic [1:0] STEP_HI  = 2'd3;

	logic              state_q, state_d;
	logic [1:0]        step_q, step_d;
	logic [1:0]        rnd_q, rnd_d;
	logic              half_q, half_d;
	logic              last_q, last_d;
	sip_state_t        v_q, v_d, h;
	logic [WordW-1:0]  m_q, m_d;
	logic [WordW-1:0]  key_low_q, key_low_d, key_high_q, key_high_d;
	logic [WordW-1:0]  part_q, part_d;
	logic [CountW-1:0] count_q, count_d;
	logic [LenW-1:0]   len_q, len_d;
	logic              out_valid_q;
	logic [WordW-1:0]  hash_q, hash_d;
	logic              upper_q, upper_d;
	logic              out_load;
	pack_res_t         pk;
	logic              in_xfer, cfg_xfer, out_xfer;
	logic              round_end, run_done, slot_free, stall;
	logic [WordW-1:0]  mf;

	sh13_pack u_pack (
		.data   (chunk.chunk_data),
		.nbytes (chunk.chunk_bytes),
		.part   (part_q),
		.count  (count_q),
		.len    (len_q),
		.res    (pk)
	);

	sh13_half u_half (
		.v_in   (v_q),
		.second (half_q),
		.v_out  (h)
	);

	// Key writes win over chunks; both only happen while idle
	assign cfg.ready   = (state_q == ST_IDLE);
	assign chunk.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign cfg_xfer    = cfg.valid && cfg.ready;
	assign in_xfer     = chunk.valid && chunk.ready;
	assign out_xfer    = hash.valid && hash.ready;

	assign hash.valid      = out_valid_q;
	assign hash.hash_word  = hash_q;
	assign hash.upper_half = upper_q;
	assign hash.final_word = upper_q;

	assign round_end = (state_q == ST_RND) && half_q;
	assign run_done  = round_end && (rnd_q == 2'd1);
	assign slot_free = !out_valid_q || hash.ready;
	// Hold the last half-round until the output register can take a result
	assign stall     = run_done && (step_q == STEP_LO || step_q == STEP_HI) && !slot_free;

	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		rnd_d      = rnd_q;
		half_d     = half_q;
		last_d     = last_q;
		v_d        = v_q;
		m_d        = m_q;
		key_low_d  = key_low_q;
		key_high_d = key_high_q;
		part_d     = part_q;
		count_d    = count_q;
		len_d      = len_q;
		hash_d     = hash_q;
		upper_d    = upper_q;
		out_load   = 1'b0;
		mf         = final_block(len_q, part_q);

		if (cfg_xfer) begin
			if (cfg.reg_index == RegKeyLow) begin
				key_low_d = cfg.wr_data;
			end
			if (cfg.reg_index == RegKeyHigh) begin
				key_high_d = cfg.wr_data;
			end
			if (cfg.reg_index == RegKeyLow || cfg.reg_index == RegKeyHigh) begin
				v_d     = sip_init(key_low_d, key_high_d);
				part_d  = '0;
				count_d = '0;
				len_d   = '0;
			end
		end else if (in_xfer) begin
			part_d  = pk.part;
			count_d = pk.count;
			len_d   = pk.len;
			last_d  = chunk.end_of_message;
			half_d  = 1'b0;
			rnd_d   = 2'd1;
			if (pk.full) begin
				// Compress the completed word first
				v_d.v3  = v_q.v3 ^ pk.word;
				m_d     = pk.word;
				step_d  = STEP_MSG;
				state_d = ST_RND;
			end else if (chunk.end_of_message) begin
				mf      = final_block(pk.len, pk.part);
				v_d.v3  = v_q.v3 ^ mf;
				m_d     = mf;
				step_d  = STEP_FIN;
				state_d = ST_RND;
			end
		end else if (state_q == ST_RND && !stall) begin
			v_d    = h;
			half_d = !half_q;
			if (round_end) begin
				if (rnd_q != 2'd1) begin
					rnd_d = rnd_q - 2'd1;
				end else begin
					case (step_q)
						STEP_MSG: begin
							v_d.v0 = h.v0 ^ m_q;
							if (last_q) begin
								v_d.v3 = h.v3 ^ mf;
								m_d    = mf;
								rnd_d  = 2'd1;
								step_d = STEP_FIN;
							end else begin
								state_d = ST_IDLE;
							end
						end
						STEP_FIN: begin
							v_d.v0 = h.v0 ^ m_q;
							v_d.v2 = h.v2 ^ FinLo;
							rnd_d  = 2'd3;
							step_d = STEP_LO;
						end
						STEP_LO: begin
							out_load = 1'b1;
							hash_d   = h.v0 ^ h.v1 ^ h.v2 ^ h.v3;
							upper_d  = 1'b0;
							v_d.v1   = h.v1 ^ FinHi;
							rnd_d    = 2'd3;
							step_d   = STEP_HI;
						end
						STEP_HI: begin
							out_load = 1'b1;
							hash_d   = h.v0 ^ h.v1 ^ h.v2 ^ h.v3;
							upper_d  = 1'b1;
							// Restart for the next message
							v_d      = sip_init(key_low_q, key_high_q);
							part_d   = '0;
							count_d  = '0;
							len_d    = '0;
							state_d  = ST_IDLE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_MSG;
			rnd_q       <= 2'd0;
			half_q      <= 1'b0;
			last_q      <= 1'b0;
			v_q         <= sip_init('0, '0);
			key_low_q   <= '0;
			key_high_q  <= '0;
			part_q      <= '0;
			count_q     <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			step_q     <= step_d;
			rnd_q      <= rnd_d;
			half_q     <= half_d;
			last_q     <= last_d;
			v_q        <= v_d;
			key_low_q  <= key_low_d;
			key_high_q <= key_high_d;
			part_q     <= part_d;
			count_q    <= count_d;
			len_q      <= len_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		m_q     <= m_d;
		hash_q  <= hash_d;
		upper_q <= upper_d;
	end

endmodule

// ===== hw/rtl/sh13_pack.sv =====
// Byte packer: merges a chunk into the partial word and counts the length.
module sh13_pack import sh13_pkg::*; (
	input  logic [WordW-1:0]  data,
	input  logic [BytesW-1:0] nbytes,
	input  logic [WordW-1:0]  part,
	input  logic [CountW-1:0] count,
	input  logic [LenW-1:0]   len,
	output pack_res_t         res
);

	logic [BytesW-1:0] n;
	logic [WordW-1:0]  masked;
	logic [BytesW-1:0] total;
	logic [WordW-1:0]  merged;
	logic [6:0]        rsh;

	always_comb begin
		n = (nbytes > BytesW'(8)) ? BytesW'(8) : nbytes;
		for (int i = 0; i < 8; i++) begin
			masked[8*i +: 8] = (BytesW'(i) < n) ? data[8*i +: 8] : 8'h00;
		end
		total  = BytesW'(count) + n;
		merged = part | (masked << {count, 3'b000});
		rsh    = 7'd64 - {1'b0, count, 3'b000};

		res.full = total[3];
		res.word = merged;
		res.len  = len + {{(LenW-BytesW){1'b0}}, n};
		if (total[3]) begin
			res.part  = (count == '0) ? '0 : (masked >> rsh);
			res.count = total[CountW-1:0];
		end else begin
			res.part  = merged;
			res.count = total[CountW-1:0];
		end
	end

endmodule

// ===== hw/rtl/sh13_half.sv =====
// Shared half-SipRound unit: two 64-bit adds with their rotates and xors.
module sh13_half import sh13_pkg::*; (
	input  sip_state_t v_in,
	input  logic       second,
	output sip_state_t v_out
);

	logic [WordW-1:0] a0, a2;

	always_comb begin
		// First half pairs v0 with v1, second half pairs v0 with v3
		a0 = v_in.v0 + (second ? v_in.v3 : v_in.v1);
		a2 = v_in.v2 + (second ? v_in.v1 : v_in.v3);
		if (!second) begin
			v_out.v0 = {a0[31:0], a0[63:32]};
			v_out.v1 = {v_in.v1[50:0], v_in.v1[63:51]} ^ a0;
			v_out.v2 = a2;
			v_out.v3 = {v_in.v3[47:0], v_in.v3[63:48]} ^ a2;
		end else begin
			v_out.v0 = a0;
			v_out.v3 = {v_in.v3[42:0], v_in.v3[63:43]} ^ a0;
			v_out.v2 = {a2[31:0], a2[63:32]};
			v_out.v1 = {v_in.v1[46:0], v_in.v1[63:47]} ^ a2;
		end
	end

endmodule

// ===== hw/rtl/sh13_chk.sv =====
// Port-level checker for the SipHash-1-3 stream block, bound to the top level.
module sh13_chk import sh13_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_last,
	input logic             out_valid,
	input logic             out_ready,
	input logic [WordW-1:0] out_word,
	input logic             out_upper,
	input logic             out_final
);

	// A stalled hash word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_upper))
		else $error("hash word changed while stalled");

	a_half_tags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_upper == out_final)
		else $error("upper_half and final_word disagree");

	// Finalization runs further rounds, so the block drops ready after a last chunk
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("chunk taken right after end of message");

	// Only the high half can follow a low half
	a_hi_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_upper |=> !out_valid || out_upper)
		else $error("low half followed by another low half");

	// While a low half waits, the message is still finalizing
	a_lo_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_upper |-> !in_ready)
		else $error("chunk accepted during finalization");

endmodule

bind siphash_1_3_128_stream sh13_chk u_sh13_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chunk.valid),
	.in_ready  (chunk.ready),
	.in_last   (chunk.end_of_message),
	.out_valid (hash.valid),
	.out_ready (hash.ready),
	.out_word  (hash.hash_word),
	.out_upper (hash.upper_half),
	.out_final (hash.final_word)
);
